>>> design/upd_pkg.sv
// shared types, constants and codes for the unordered pair table
package upd_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int ID_BITS     = 16;
   localparam int KEY_BITS    = 2 * ID_BITS;
   localparam int HND_BITS    = 32;
   localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
   localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_ERASE  = 3'd1;
   localparam logic [2:0] ACT_FIND   = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;
   localparam logic [2:0] ACT_READ   = 3'd4;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [1:0] RD_SCAN  = 2'd0;
   localparam logic [1:0] RD_LAST  = 2'd1;
   localparam logic [1:0] RD_INDEX = 2'd2;

   localparam logic WR_APPEND = 1'b0;
   localparam logic WR_MOVE   = 1'b1;

   localparam logic [1:0] SLOT_ZERO  = 2'd0;
   localparam logic [1:0] SLOT_HIT   = 2'd1;
   localparam logic [1:0] SLOT_COUNT = 2'd2;
   localparam logic [1:0] SLOT_INDEX = 2'd3;

   localparam logic [1:0] HND_ZERO = 2'd0;
   localparam logic [1:0] HND_HIT  = 2'd1;
   localparam logic [1:0] HND_REQ  = 2'd2;
   localparam logic [1:0] HND_READ = 2'd3;

   localparam logic [1:0] IDS_ZERO = 2'd0;
   localparam logic [1:0] IDS_KEY  = 2'd1;
   localparam logic [1:0] IDS_READ = 2'd2;

   typedef struct packed {
      logic [2:0]           action;
      logic [ID_BITS-1:0]   first_id;
      logic [ID_BITS-1:0]   second_id;
      logic [HND_BITS-1:0]  entry_handle;
      logic [SLOT_BITS-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_BITS-1:0]  slot;
      logic [HND_BITS-1:0]   handle_out;
      logic [ID_BITS-1:0]    low_id_out;
      logic [ID_BITS-1:0]    high_id_out;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic       req_load;
      logic       scan_clear;
      logic       scan_en;
      logic       capture;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic [1:0] slot_sel;
      logic [1:0] hnd_sel;
      logic [1:0] ids_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       count_zero;
      logic       count_full;
      logic       match;
      logic       last;
      logic       index_ok;
      logic       move_needed;
   } stat_type;

endpackage

>>> design/upd_dp.sv
// datapath: key and handle memories, fill count, scan pointer and result register
module upd_dp import upd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   logic [KEY_BITS-1:0]   key_mem [MAX_ENTRIES];
   logic [HND_BITS-1:0]   hnd_mem [MAX_ENTRIES];

   logic [2:0]            action_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [HND_BITS-1:0]   hnd_req_ff;
   logic [SLOT_BITS-1:0]  index_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] scan_ff, scan_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [SLOT_BITS-1:0]  cmp_idx_ff;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [HND_BITS-1:0]   hnd_rd_ff;
   logic [SLOT_BITS-1:0]  hit_slot_ff;
   logic [HND_BITS-1:0]   hit_hnd_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [ID_BITS-1:0]    low_id, high_id;
   logic                  scan_lt;
   logic [COUNT_BITS-1:0] count_less;
   logic [SLOT_BITS-1:0]  rd_addr, wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [HND_BITS-1:0]   wr_hnd;

   assign low_id  = (req_data.first_id < req_data.second_id) ?
                    req_data.first_id : req_data.second_id;
   assign high_id = (req_data.first_id < req_data.second_id) ?
                    req_data.second_id : req_data.first_id;

   assign scan_lt    = scan_ff < count_ff;
   assign count_less = count_ff - COUNT_BITS'(1);
   assign cmp_vld_in = cmd.scan_en & scan_lt;

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_en && scan_lt) begin
         scan_in = scan_ff + COUNT_BITS'(1);
      end
   end

   always_comb begin
      priority if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_less;
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_LAST:  rd_addr = count_less[SLOT_BITS-1:0];
         RD_INDEX: rd_addr = index_ff;
         default:  rd_addr = scan_ff[SLOT_BITS-1:0];
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_MOVE: begin
            wr_addr = hit_slot_ff;
            wr_key  = key_rd_ff;
            wr_hnd  = hnd_rd_ff;
         end
         default: begin
            wr_addr = count_ff[SLOT_BITS-1:0];
            wr_key  = key_ff;
            wr_hnd  = hnd_req_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_mem[wr_addr] <= wr_key;
         hnd_mem[wr_addr] <= wr_hnd;
      end
      key_rd_ff <= key_mem[rd_addr];
      hnd_rd_ff <= hnd_mem[rd_addr];
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = cmd.rsp_status;
      rsp_in.entry_count = count_in;
      unique case (cmd.slot_sel)
         SLOT_HIT:   rsp_in.slot = hit_slot_ff;
         SLOT_COUNT: rsp_in.slot = count_ff[SLOT_BITS-1:0];
         SLOT_INDEX: rsp_in.slot = index_ff;
         default:    rsp_in.slot = '0;
      endcase
      unique case (cmd.hnd_sel)
         HND_HIT:  rsp_in.handle_out = hit_hnd_ff;
         HND_REQ:  rsp_in.handle_out = hnd_req_ff;
         HND_READ: rsp_in.handle_out = hnd_rd_ff;
         default:  rsp_in.handle_out = '0;
      endcase
      unique case (cmd.ids_sel)
         IDS_KEY: begin
            rsp_in.low_id_out  = key_ff[KEY_BITS-1:ID_BITS];
            rsp_in.high_id_out = key_ff[ID_BITS-1:0];
         end
         IDS_READ: begin
            rsp_in.low_id_out  = key_rd_ff[KEY_BITS-1:ID_BITS];
            rsp_in.high_id_out = key_rd_ff[ID_BITS-1:0];
         end
         default: begin
            rsp_in.low_id_out  = '0;
            rsp_in.high_id_out = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         action_ff  <= req_data.action;
         key_ff     <= {low_id, high_id};
         hnd_req_ff <= req_data.entry_handle;
         index_ff   <= req_data.slot_index;
      end
      cmp_idx_ff <= scan_ff[SLOT_BITS-1:0];
      if (cmd.capture) begin
         hit_slot_ff <= cmp_idx_ff;
         hit_hnd_ff  <= hnd_rd_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.action      = action_ff;
   assign stat.count_zero  = (count_ff == '0);
   assign stat.count_full  = (count_ff == COUNT_BITS'(MAX_ENTRIES));
   assign stat.match       = cmp_vld_ff && (key_rd_ff == key_ff);
   assign stat.last        = cmp_vld_ff && ({1'b0, cmp_idx_ff} == count_less);
   assign stat.index_ok    = {1'b0, index_ff} < count_ff;
   assign stat.move_needed = {1'b0, hit_slot_ff} != count_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/upd_ctrl.sv
// controller state machine that sequences search, append, swap-remove, clear and reads
module upd_ctrl import upd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_FOUND  = 3'd3;
   localparam logic [2:0] S_MISS   = 3'd4;
   localparam logic [2:0] S_MOVE   = 3'd5;
   localparam logic [2:0] S_READ   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.req_load   = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.action)
               ACT_INSERT, ACT_ERASE, ACT_FIND: begin
                  state_in = stat.count_zero ? S_MISS : S_SEARCH;
               end
               ACT_CLEAR: begin
                  cmd.cnt_clr    = 1'b1;
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_DONE;
                  state_in       = S_IDLE;
               end
               ACT_READ: begin
                  if (stat.index_ok) begin
                     cmd.rd_sel = RD_INDEX;
                     state_in   = S_READ;
                  end else begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_FULL;
                     cmd.slot_sel   = SLOT_INDEX;
                     state_in       = S_IDLE;
                  end
               end
               default: begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_DONE;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_SEARCH: begin
            cmd.scan_en = 1'b1;
            cmd.rd_sel  = RD_SCAN;
            priority if (stat.match) begin
               cmd.capture = 1'b1;
               state_in    = S_FOUND;
            end else if (stat.last) begin
               state_in = S_MISS;
            end
         end
         S_FOUND: begin
            cmd.slot_sel = SLOT_HIT;
            cmd.hnd_sel  = HND_HIT;
            cmd.ids_sel  = IDS_KEY;
            unique case (stat.action)
               ACT_INSERT: begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_PRESENT;
                  state_in       = S_IDLE;
               end
               ACT_ERASE: begin
                  cmd.cnt_dec = 1'b1;
                  cmd.rd_sel  = RD_LAST;
                  state_in    = S_MOVE;
               end
               default: begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_DONE;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_MISS: begin
            cmd.rsp_load = 1'b1;
            cmd.ids_sel  = IDS_KEY;
            state_in     = S_IDLE;
            if (stat.action == ACT_INSERT) begin
               if (stat.count_full) begin
                  cmd.rsp_status = ST_FULL;
               end else begin
                  cmd.wr_en      = 1'b1;
                  cmd.wr_sel     = WR_APPEND;
                  cmd.cnt_inc    = 1'b1;
                  cmd.rsp_status = ST_DONE;
                  cmd.slot_sel   = SLOT_COUNT;
                  cmd.hnd_sel    = HND_REQ;
               end
            end else begin
               cmd.rsp_status = ST_ABSENT;
            end
         end
         S_MOVE: begin
            cmd.wr_en      = stat.move_needed;
            cmd.wr_sel     = WR_MOVE;
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = ST_DONE;
            cmd.slot_sel   = SLOT_HIT;
            cmd.hnd_sel    = HND_HIT;
            cmd.ids_sel    = IDS_KEY;
            state_in       = S_IDLE;
         end
         S_READ: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = ST_DONE;
            cmd.slot_sel   = SLOT_INDEX;
            cmd.hnd_sel    = HND_READ;
            cmd.ids_sel    = IDS_READ;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/unordered_pair_dense_table_top.sv
// top level of the densely packed unordered pair table
// A request is taken when start is high and busy is low; busy then stays high until the
// result is presented. Each result appears for exactly one cycle with rsp_valid high and
// cannot be held off, so the receiver must take it then. Clear, bad slot reads and
// undefined actions are answered from the decode state, a valid slot read after the
// memory read state. Insert, erase and find scan the occupied slots one per cycle through
// the single read port of the key memory, from slot 0 until a match or the last slot;
// erase then moves the last entry into the freed slot. There is no clearing pass after
// reset: clear only zeroes the fill count.
module unordered_pair_dense_table_top import upd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   upd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   upd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/upd_chk.sv
// port-level checker for the unordered pair table and its bind
module upd_chk import upd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every transfer in makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request transfer");

   // a result only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   // busy drops exactly when a result comes out
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= COUNT_BITS'(MAX_ENTRIES)))
      else $error("entry count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_PRESENT) |-> (rsp_data.entry_count != '0))
      else $error("duplicate reported in an empty table");

endmodule

bind unordered_pair_dense_table_top upd_chk u_upd_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

>>> sim/unordered_pair_dense_table_checker.sv
// checker for the unordered pair table: predicts each result and compares it with the block
module unordered_pair_dense_table_checker import upd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding,
   output int      results_seen,
   output int      full_rejects,
   output int      peak_fill
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [KEY_BITS-1:0] pair_keys    [MAX_ENTRIES];
   logic [HND_BITS-1:0] pair_handles [MAX_ENTRIES];
   int unsigned         fill;
   rsp_type             expected_q[$];
   rsp_type             want;
   int                  bad_n;
   int                  seen_n;
   int                  reject_n;
   int                  peak_n;

   function automatic rsp_type apply_pair_op(req_type r);
      rsp_type             o;
      logic [ID_BITS-1:0]  lo;
      logic [ID_BITS-1:0]  hi;
      logic [KEY_BITS-1:0] key;
      logic [KEY_BITS-1:0] held;
      int unsigned         hit;
      lo = (r.first_id < r.second_id) ? r.first_id : r.second_id;
      hi = (r.first_id < r.second_id) ? r.second_id : r.first_id;
      key = {lo, hi};
      hit = fill;
      for (int unsigned s = 0; s < fill; s++) begin
         if (hit == fill && pair_keys[SLOT_BITS'(s)] == key) hit = s;
      end
      o = '0;
      o.status = ST_DONE;
      o.low_id_out = lo;
      o.high_id_out = hi;
      case (r.action)
         ACT_INSERT: begin
            if (hit < fill) begin
               o.status = ST_PRESENT;
               o.slot = SLOT_BITS'(hit);
               o.handle_out = pair_handles[SLOT_BITS'(hit)];
            end else if (fill >= MAX_ENTRIES) begin
               o.status = ST_FULL;
               reject_n++;
            end else begin
               pair_keys[SLOT_BITS'(fill)] = key;
               pair_handles[SLOT_BITS'(fill)] = r.entry_handle;
               o.slot = SLOT_BITS'(fill);
               o.handle_out = r.entry_handle;
               fill++;
            end
         end
         ACT_ERASE: begin
            if (hit < fill) begin
               o.slot = SLOT_BITS'(hit);
               o.handle_out = pair_handles[SLOT_BITS'(hit)];
               fill--;
               if (hit < fill) begin
                  pair_keys[SLOT_BITS'(hit)] = pair_keys[SLOT_BITS'(fill)];
                  pair_handles[SLOT_BITS'(hit)] = pair_handles[SLOT_BITS'(fill)];
               end
            end else begin
               o.status = ST_ABSENT;
            end
         end
         ACT_FIND: begin
            if (hit < fill) begin
               o.slot = SLOT_BITS'(hit);
               o.handle_out = pair_handles[SLOT_BITS'(hit)];
            end else begin
               o.status = ST_ABSENT;
            end
         end
         ACT_CLEAR: begin
            fill = 0;
            o.low_id_out = '0;
            o.high_id_out = '0;
         end
         ACT_READ: begin
            o.slot = r.slot_index;
            if (r.slot_index < fill) begin
               held = pair_keys[r.slot_index];
               o.handle_out = pair_handles[r.slot_index];
               o.low_id_out = held[KEY_BITS-1:ID_BITS];
               o.high_id_out = held[ID_BITS-1:0];
            end else begin
               o.status = ST_FULL;
               o.low_id_out = '0;
               o.high_id_out = '0;
            end
         end
         default: begin
            o.low_id_out = '0;
            o.high_id_out = '0;
         end
      endcase
      if (fill > peak_n) peak_n = fill;
      o.entry_count = COUNT_BITS'(fill);
      return o;
   endfunction

   task automatic flag_field(string field, longint unsigned exp_v, longint unsigned got_v);
      bad_n++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, got_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill = 0;
         expected_q.delete();
         bad_n = 0;
         seen_n = 0;
         reject_n = 0;
         peak_n = 0;
      end else begin
         if (start && !busy) expected_q.push_back(apply_pair_op(req_data));
         if (rsp_valid) begin
            seen_n++;
            if (expected_q.size() == 0) begin
               bad_n++;
               $display("%0t: result with nothing pending, expected none actual %p",
                        $time, rsp_data);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status)
                  flag_field("status", want.status, rsp_data.status);
               if (rsp_data.slot !== want.slot)
                  flag_field("slot", want.slot, rsp_data.slot);
               if (rsp_data.handle_out !== want.handle_out)
                  flag_field("handle_out", want.handle_out, rsp_data.handle_out);
               if (rsp_data.low_id_out !== want.low_id_out)
                  flag_field("low_id_out", want.low_id_out, rsp_data.low_id_out);
               if (rsp_data.high_id_out !== want.high_id_out)
                  flag_field("high_id_out", want.high_id_out, rsp_data.high_id_out);
               if (rsp_data.entry_count !== want.entry_count)
                  flag_field("entry_count", want.entry_count, rsp_data.entry_count);
            end
         end
      end
      mismatches <= bad_n;
      outstanding <= expected_q.size();
      results_seen <= seen_n;
      full_rejects <= reject_n;
      peak_fill <= peak_n;
   end

endmodule

>>> sim/tb_unordered_pair_dense_table_top.sv
// testbench top for the unordered pair table: stimulus, watchdog and verdict
module tb_unordered_pair_dense_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import upd_pkg::*;

   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         DRAIN_CYCLES   = 300;
   localparam int         ID_POOL        = 15;
   localparam int         FILL_BASE      = 16'h1000;
   localparam int         REQ_W          = $bits(req_type);
   localparam logic [2:0] ACT_RSV_A      = 3'd5;
   localparam logic [2:0] ACT_RSV_C      = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   int idle_pct = 27;
   int items_sent = 0;
   int quiet_cycles = 0;
   int mismatches;
   int outstanding;
   int results_seen;
   int full_rejects;
   int peak_fill;

   logic [ID_BITS-1:0] fill_lo[$];
   logic [ID_BITS-1:0] fill_hi[$];

   always #6 clock = ~clock;

   unordered_pair_dense_table_top u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   unordered_pair_dense_table_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .results_seen(results_seen),
      .full_rejects(full_rejects),
      .peak_fill   (peak_fill)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [ID_BITS-1:0] pick_id();
      return ($urandom_range(9) == 0) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(ID_POOL));
   endfunction

   task automatic pair_transfer(input logic [2:0] act, input logic [ID_BITS-1:0] a,
                                input logic [ID_BITS-1:0] b, input logic [HND_BITS-1:0] h,
                                input logic [SLOT_BITS-1:0] idx);
      @(negedge clock);
      start <= 1'b1;
      req_data <= '{action: act, first_id: a, second_id: b, entry_handle: h, slot_index: idx};
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         req_data <= req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      end
   endtask

   task automatic random_op();
      logic [2:0]           act;
      logic [SLOT_BITS-1:0] idx;
      int                   roll;
      roll = $urandom_range(99);
      if (roll < 35) act = ACT_INSERT;
      else if (roll < 55) act = ACT_ERASE;
      else if (roll < 80) act = ACT_FIND;
      else if (roll < 92) act = ACT_READ;
      else if (roll < 95) act = ACT_CLEAR;
      else act = 3'($urandom_range(ACT_RSV_C, ACT_RSV_A));
      idx = ($urandom_range(9) == 0) ? SLOT_BITS'($urandom)
                                     : SLOT_BITS'($urandom_range(2 * ID_POOL));
      pair_transfer(act, pick_id(), pick_id(), $urandom, idx);
   endtask

   initial begin
      logic [ID_BITS-1:0] lo;
      logic [ID_BITS-1:0] hi;
      int                 k;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicates, swap-last erase, undefined codes
      pair_transfer(ACT_FIND,   16'd3,      16'd5,      32'h0,        8'd0);
      pair_transfer(ACT_ERASE,  16'd3,      16'd5,      32'h0,        8'd0);
      pair_transfer(ACT_READ,   16'd0,      16'd0,      32'h0,        8'd0);
      pair_transfer(ACT_READ,   16'hffff,   16'hffff,   32'hffffffff, 8'hff);
      pair_transfer(ACT_INSERT, 16'd0,      16'd0,      32'h0,        8'd0);
      pair_transfer(ACT_INSERT, 16'hffff,   16'hffff,   32'hffffffff, 8'hff);
      pair_transfer(ACT_INSERT, 16'd5,      16'd3,      32'h12345678, 8'd0);
      pair_transfer(ACT_INSERT, 16'd3,      16'd5,      32'h9abcdef0, 8'd0);
      pair_transfer(ACT_INSERT, 16'hffff,   16'd0,      32'ha5a5a5a5, 8'd0);
      pair_transfer(ACT_INSERT, 16'd0,      16'hffff,   32'h5a5a5a5a, 8'd0);
      pair_transfer(ACT_FIND,   16'd0,      16'hffff,   32'h0,        8'd0);
      pair_transfer(ACT_FIND,   16'd1,      16'd2,      32'h0,        8'd0);
      pair_transfer(ACT_READ,   16'd0,      16'd0,      32'h0,        8'd0);
      pair_transfer(ACT_READ,   16'd0,      16'd0,      32'h0,        8'd3);
      pair_transfer(ACT_READ,   16'd0,      16'd0,      32'h0,        8'd4);
      pair_transfer(ACT_ERASE,  16'hffff,   16'hffff,   32'h0,        8'd0);
      pair_transfer(ACT_READ,   16'd0,      16'd0,      32'h0,        8'd1);
      pair_transfer(ACT_ERASE,  16'd0,      16'hffff,   32'h0,        8'd0);
      pair_transfer(ACT_ERASE,  16'd5,      16'd3,      32'h0,        8'd0);
      pair_transfer(ACT_ERASE,  16'd5,      16'd3,      32'h0,        8'd0);
      pair_transfer(ACT_RSV_A,  16'h1234,   16'h5678,   32'hdeadbeef, 8'h55);
      pair_transfer(ACT_RSV_C,  16'hffff,   16'hffff,   32'hffffffff, 8'hff);
      pair_transfer(ACT_CLEAR,  16'hffff,   16'h0001,   32'hffffffff, 8'hff);
      pair_transfer(ACT_READ,   16'd0,      16'd0,      32'h0,        8'd0);
      pair_transfer(ACT_FIND,   16'd0,      16'd0,      32'h0,        8'd0);

      repeat (220) random_op();

      // fill the table to the top, then work on it while full
      idle_pct = 69;
      pair_transfer(ACT_CLEAR, pick_id(), pick_id(), $urandom, 8'($urandom));
      for (int n = 0; n < MAX_ENTRIES; n++) begin
         lo = ID_BITS'(FILL_BASE + n);
         hi = 16'h8000 | ID_BITS'($urandom);
         fill_lo.push_back(lo);
         fill_hi.push_back(hi);
         if ($urandom_range(1)) pair_transfer(ACT_INSERT, lo, hi, $urandom, 8'($urandom));
         else pair_transfer(ACT_INSERT, hi, lo, $urandom, 8'($urandom));
      end
      repeat (40) begin
         k = $urandom_range(fill_lo.size() - 1);
         case ($urandom_range(3))
            0: pair_transfer(ACT_INSERT, pick_id(), pick_id(), $urandom, 8'($urandom));
            1: pair_transfer(ACT_INSERT, fill_hi[k], fill_lo[k], $urandom, 8'($urandom));
            2: pair_transfer(ACT_FIND, fill_lo[k], fill_hi[k], $urandom, 8'($urandom));
            default: pair_transfer(ACT_READ, pick_id(), pick_id(), $urandom, 8'($urandom));
         endcase
      end
      pair_transfer(ACT_ERASE, fill_hi[0], fill_lo[0], $urandom, 8'($urandom));
      fill_lo.delete(0);
      fill_hi.delete(0);
      pair_transfer(ACT_INSERT, 16'd9, 16'd7, $urandom, 8'($urandom));
      pair_transfer(ACT_READ, pick_id(), pick_id(), $urandom, 8'hff);
      repeat (30) begin
         k = $urandom_range(fill_lo.size() - 1);
         case ($urandom_range(2))
            0: begin
               pair_transfer(ACT_ERASE, fill_lo[k], fill_hi[k], $urandom, 8'($urandom));
               fill_lo.delete(k);
               fill_hi.delete(k);
            end
            1: pair_transfer(ACT_FIND, fill_hi[k], fill_lo[k], $urandom, 8'($urandom));
            default: pair_transfer(ACT_READ, pick_id(), pick_id(), $urandom, 8'($urandom));
         endcase
      end

      idle_pct = 0;
      repeat (230) random_op();

      @(negedge clock);
      start <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests sent, %0d results checked, peak fill %0d of %0d",
               items_sent, results_seen, peak_fill, MAX_ENTRIES);
      $display("summary: %0d inserts refused by a full table, %0d mismatches",
               full_rejects, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
